[rtl/core/sbfr_pkg.sv]
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared widths, types and helpers of the body frame rotation pipeline.
// ----------------------------------------------------------------------------
package sbfr_pkg;

   localparam int POS_WIDTH_DEF = 40;
   localparam int FRAC_BITS_DEF = 30;

   localparam int RED_W  = 30;             // reduced component, signed
   localparam int RED_SH = RED_W - 2;      // sign-differing bit above this forces a shift
   localparam int MAG_W  = 30;             // magnitude of a reduced component
   localparam int PROD_W = 2 * RED_W;      // product of two reduced components
   localparam int C_W    = PROD_W + 1;     // cross product component
   localparam int SQ_W   = 2 * MAG_W - 1;  // square of a magnitude (<= 2^58)
   localparam int RAD_W  = 62;             // 4 * squared norm
   localparam int ROOT_W = RAD_W / 2;      // square root of the above
   localparam int OUT_W  = 32;             // Q1.F output words
   localparam int XP_W   = 2 * OUT_W;      // product of two output words
   localparam int K_W    = 7;              // shift amount of a range reduction
   localparam int SRCH_W = 64;             // width seen by the shift search

   // Lanes 0..2 carry the Z axis, lanes 3..5 the Y axis.
   typedef struct packed {
      logic [5:0][MAG_W-1:0] mag;
      logic [5:0]            neg;
      logic                  deg;
   } sbfr_tag_type;

   // Smallest right shift that brings every component into the reduced range,
   // given the OR over components of (value xor its sign).
   function automatic logic [K_W-1:0] red_k(input logic [SRCH_W-1:0] d);
      int h;
      h = 0;
      for (int j = 0; j < SRCH_W; j++) begin
         if (d[j]) h = j;
      end
      if (h > RED_SH) return K_W'(h - RED_SH);
      return '0;
   endfunction

endpackage

[rtl/core/sbfr_if.sv]
// ----------------------------------------------------------------------------
// sbfr_req_if / sbfr_rsp_if
// Valid/ready channels of the body frame rotation block.
// ----------------------------------------------------------------------------
interface sbfr_req_if #(parameter int POS_WIDTH = 40);
   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] sat_pos_x;
   logic signed [POS_WIDTH-1:0] sat_pos_y;
   logic signed [POS_WIDTH-1:0] sat_pos_z;
   logic signed [POS_WIDTH-1:0] sun_pos_x;
   logic signed [POS_WIDTH-1:0] sun_pos_y;
   logic signed [POS_WIDTH-1:0] sun_pos_z;

   modport source (output valid, sat_pos_x, sat_pos_y, sat_pos_z,
                   sun_pos_x, sun_pos_y, sun_pos_z, input ready);
   modport sink   (input valid, sat_pos_x, sat_pos_y, sat_pos_z,
                   sun_pos_x, sun_pos_y, sun_pos_z, output ready);
endinterface

interface sbfr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] axis_x_0;
   logic signed [31:0] axis_x_1;
   logic signed [31:0] axis_x_2;
   logic signed [31:0] axis_y_0;
   logic signed [31:0] axis_y_1;
   logic signed [31:0] axis_y_2;
   logic signed [31:0] axis_z_0;
   logic signed [31:0] axis_z_1;
   logic signed [31:0] axis_z_2;
   logic               degenerate;

   modport source (output valid, axis_x_0, axis_x_1, axis_x_2, axis_y_0, axis_y_1,
                   axis_y_2, axis_z_0, axis_z_1, axis_z_2, degenerate, input ready);
   modport sink   (input valid, axis_x_0, axis_x_1, axis_x_2, axis_y_0, axis_y_1,
                   axis_y_2, axis_z_0, axis_z_1, axis_z_2, degenerate, output ready);
endinterface

[rtl/core/sbfr_isqrt.sv]
// ----------------------------------------------------------------------------
// sbfr_isqrt
// Two integer square roots, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module sbfr_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [sbfr_pkg::RAD_W-1:0] in_rad [2],
   input  sbfr_pkg::sbfr_tag_type    in_tag,
   output logic                      out_valid,
   output logic [sbfr_pkg::ROOT_W-1:0] out_root [2],
   output sbfr_pkg::sbfr_tag_type    out_tag
);
   import sbfr_pkg::*;

   localparam int ITER = RAD_W / 2;

   logic [RAD_W-1:0] n_ff   [ITER+1][2];
   logic [RAD_W-1:0] res_ff [ITER+1][2];
   logic             valid_ff [ITER+1];
   sbfr_tag_type     tag_ff [ITER+1];

   assign valid_ff[0] = in_valid;
   assign tag_ff[0]   = in_tag;
   assign n_ff[0]     = in_rad;
   assign res_ff[0]   = '{default: '0};

   for (genvar j = 0; j < ITER; j++) begin : g_stage
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * j);
      logic [RAD_W-1:0] n_in   [2];
      logic [RAD_W-1:0] res_in [2];
      logic [RAD_W:0]   trial;

      always_comb begin
         trial = '0;
         for (int l = 0; l < 2; l++) begin
            trial = {1'b0, res_ff[j][l]} + {1'b0, BIT};
            if ({1'b0, n_ff[j][l]} >= trial) begin
               n_in[l]   = n_ff[j][l] - trial[RAD_W-1:0];
               res_in[l] = (res_ff[j][l] >> 1) + BIT;
            end else begin
               n_in[l]   = n_ff[j][l];
               res_in[l] = res_ff[j][l] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (en) begin
            n_ff[j+1]   <= n_in;
            res_ff[j+1] <= res_in;
            tag_ff[j+1] <= tag_ff[j];
         end
      end
   end

   assign out_valid   = valid_ff[ITER];
   assign out_tag     = tag_ff[ITER];
   assign out_root[0] = res_ff[ITER][0][ROOT_W-1:0];
   assign out_root[1] = res_ff[ITER][1][ROOT_W-1:0];

endmodule

[rtl/core/sbfr_div.sv]
// ----------------------------------------------------------------------------
// sbfr_div
// Six rounded divisions |v_i| * 2^(F+1) / r, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbfr_div #(
   parameter int FRAC_BITS = sbfr_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [sbfr_pkg::ROOT_W-1:0] in_root [2],
   input  sbfr_pkg::sbfr_tag_type      in_tag,
   output logic                        out_valid,
   output logic [FRAC_BITS+1:0]        out_quot [6],
   output sbfr_pkg::sbfr_tag_type      out_tag
);
   import sbfr_pkg::*;

   localparam int Q_W   = FRAC_BITS + 2;
   localparam int NUM_W = ROOT_W + FRAC_BITS + 1;

   logic [NUM_W-1:0]  rem_ff  [Q_W+1][6];
   logic [ROOT_W-1:0] div_ff  [Q_W+1][2];
   logic [Q_W-1:0]    quot_ff [Q_W+1][6];
   logic              valid_ff [Q_W+1];
   sbfr_tag_type      tag_ff [Q_W+1];

   logic [NUM_W-1:0]  num_in [6];
   logic [ROOT_W-1:0] div_in [2];

   // Form the rounded numerators; a zero root only occurs for a flagged item.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         div_in[l] = (in_root[l] == '0) ? ROOT_W'(1) : in_root[l];
      end
      for (int i = 0; i < 6; i++) begin
         num_in[i] = (NUM_W'(in_tag.mag[i]) << (FRAC_BITS + 1))
                   + NUM_W'(div_in[i / 3] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= num_in;
         div_ff[0]  <= div_in;
         quot_ff[0] <= '{default: '0};
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int SH = Q_W - 1 - s;
      logic [NUM_W-1:0] rem_in  [6];
      logic [Q_W-1:0]   quot_in [6];
      logic [NUM_W-1:0] trial;

      always_comb begin
         trial = '0;
         for (int i = 0; i < 6; i++) begin
            trial = NUM_W'(div_ff[s][i / 3]) << SH;
            if (rem_ff[s][i] >= trial) begin
               rem_in[i]  = rem_ff[s][i] - trial;
               quot_in[i] = quot_ff[s][i] | (Q_W'(1) << SH);
            end else begin
               rem_in[i]  = rem_ff[s][i];
               quot_in[i] = quot_ff[s][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (en) begin
            rem_ff[s+1]  <= rem_in;
            div_ff[s+1]  <= div_ff[s];
            quot_ff[s+1] <= quot_in;
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot  = quot_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];

endmodule

[rtl/core/satellite_body_frame_rotation.sv]
// ----------------------------------------------------------------------------
// satellite_body_frame_rotation
// Nominal-yaw spacecraft frame from satellite and sun positions, Q1.F output.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | transaction
//  req     | in  | valid / ready | satellite and sun position vectors
//  rsp     | out | valid / ready | X, Y, Z body axes and degenerate flag
//
//  One transaction per cycle in each direction while rsp is not stalled; the
//  pipeline holds the 31-stage square root and the FRAC_BITS + 3 stage
//  restoring divider.
//  Reset (synchronous) clears only the stage valid bits.
//  A result held at rsp while ready is low freezes the whole pipeline in
//  place; req.ready drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module satellite_body_frame_rotation #(
   parameter int POS_WIDTH = sbfr_pkg::POS_WIDTH_DEF,
   parameter int FRAC_BITS = sbfr_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   sbfr_req_if.sink   req,
   sbfr_rsp_if.source rsp
);
   import sbfr_pkg::*;

   localparam int Q_W = FRAC_BITS + 2;
   localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;
   localparam logic signed [XP_W-1:0]  ONE_X = XP_W'(1) << FRAC_BITS;
   localparam logic signed [XP_W-1:0]  HALF_X = XP_W'(1) << (FRAC_BITS - 1);

   // Global advance: move everything whenever the output slot is free or taken.
   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   // ---- stage 1: capture positions, find the reduction shifts ----
   logic signed [POS_WIDTH-1:0] s_in [3], u_in [3];
   logic        [POS_WIDTH-1:0] s_or, u_or;
   logic signed [POS_WIDTH-1:0] s1_ff [3], u1_ff [3];
   logic [K_W-1:0]              ks_in, ku_in, ks_ff, ku_ff;
   logic                        v1_ff;

   assign s_in = '{req.sat_pos_x, req.sat_pos_y, req.sat_pos_z};
   assign u_in = '{req.sun_pos_x, req.sun_pos_y, req.sun_pos_z};

   always_comb begin
      s_or = '0;
      u_or = '0;
      for (int i = 0; i < 3; i++) begin
         s_or |= s_in[i] ^ {POS_WIDTH{s_in[i][POS_WIDTH-1]}};
         u_or |= u_in[i] ^ {POS_WIDTH{u_in[i][POS_WIDTH-1]}};
      end
      ks_in = red_k(SRCH_W'(s_or));
      ku_in = red_k(SRCH_W'(u_or));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s_in;
         u1_ff <= u_in;
         ks_ff <= ks_in;
         ku_ff <= ku_in;
      end
   end

   // ---- stage 2: floor-shift into the reduced range ----
   logic signed [RED_W-1:0] s2_in [3], u2_in [3], s2_ff [3], u2_ff [3];
   logic                    v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_in[i] = RED_W'(s1_ff[i] >>> ks_ff);
         u2_in[i] = RED_W'(u1_ff[i] >>> ku_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
         u2_ff <= u2_in;
      end
   end

   // ---- stage 3: partial products of u x s ----
   logic signed [PROD_W-1:0] p3_in [6], p3_ff [6];
   logic signed [RED_W-1:0]  s3_ff [3];
   logic                     v3_ff;

   always_comb begin
      p3_in[0] = u2_ff[1] * s2_ff[2];
      p3_in[1] = u2_ff[2] * s2_ff[1];
      p3_in[2] = u2_ff[2] * s2_ff[0];
      p3_in[3] = u2_ff[0] * s2_ff[2];
      p3_in[4] = u2_ff[0] * s2_ff[1];
      p3_in[5] = u2_ff[1] * s2_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff <= p3_in;
         s3_ff <= s2_ff;
      end
   end

   // ---- stage 4: cross product differences ----
   logic signed [C_W-1:0]   c4_in [3], c4_ff [3];
   logic signed [RED_W-1:0] s4_ff [3];
   logic                    v4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c4_in[i] = C_W'(p3_ff[2*i]) - C_W'(p3_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff <= c4_in;
         s4_ff <= s3_ff;
      end
   end

   // ---- stage 5: reduction shift of the cross product ----
   logic [C_W-1:0]          c_or;
   logic [K_W-1:0]          kc_in, kc_ff;
   logic signed [C_W-1:0]   c5_ff [3];
   logic signed [RED_W-1:0] s5_ff [3];
   logic                    v5_ff;

   always_comb begin
      c_or = '0;
      for (int i = 0; i < 3; i++) begin
         c_or |= c4_ff[i] ^ {C_W{c4_ff[i][C_W-1]}};
      end
      kc_in = red_k(SRCH_W'(c_or));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kc_ff <= kc_in;
         c5_ff <= c4_ff;
         s5_ff <= s4_ff;
      end
   end

   // ---- stage 6: reduce, flag degenerate frames, split sign and magnitude ----
   logic signed [RED_W-1:0] cr [3];
   sbfr_tag_type            t6_in, t6_ff;
   logic                    v6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr[i] = RED_W'(c5_ff[i] >>> kc_ff);
         // Z is -s, so its sign is set for a positive position.
         t6_in.mag[i]   = MAG_W'(s5_ff[i][RED_W-1] ? -s5_ff[i] : s5_ff[i]);
         t6_in.neg[i]   = !s5_ff[i][RED_W-1] && (s5_ff[i] != '0);
         t6_in.mag[3+i] = MAG_W'(cr[i][RED_W-1] ? -cr[i] : cr[i]);
         t6_in.neg[3+i] = cr[i][RED_W-1];
      end
      t6_in.deg = (s5_ff[0] == '0 && s5_ff[1] == '0 && s5_ff[2] == '0)
               || (cr[0] == '0 && cr[1] == '0 && cr[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t6_ff <= t6_in;
      end
   end

   // ---- stage 7: squares of the magnitudes ----
   logic [SQ_W-1:0] sq7_in [6], sq7_ff [6];
   sbfr_tag_type    t7_ff;
   logic            v7_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         sq7_in[i] = SQ_W'(t6_ff.mag[i] * t6_ff.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq7_ff <= sq7_in;
         t7_ff  <= t6_ff;
      end
   end

   // ---- stage 8: 4 * squared norm of each axis ----
   logic [RAD_W-1:0] rad8_in [2], rad8_ff [2];
   sbfr_tag_type     t8_ff;
   logic             v8_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rad8_in[l] = (RAD_W'(sq7_ff[3*l]) + RAD_W'(sq7_ff[3*l+1])
                     + RAD_W'(sq7_ff[3*l+2])) << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad8_ff <= rad8_in;
         t8_ff   <= t7_ff;
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // ---- square roots and divisions ----
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root [2];
   sbfr_tag_type      sq_tag;
   logic              dv_valid;
   logic [Q_W-1:0]    dv_quot [6];
   sbfr_tag_type      dv_tag;

   sbfr_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_rad    (rad8_ff),
      .in_tag    (t8_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   sbfr_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_tag    (sq_tag),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tag   (dv_tag)
   );

   // ---- stage A: saturate quotients to one, restore signs ----
   logic signed [OUT_W-1:0] ax_in [6], ax_ff [6];
   logic [Q_W-1:0]          qs;
   logic                    dga_ff, va_ff;

   always_comb begin
      qs = '0;
      for (int i = 0; i < 6; i++) begin
         qs = (dv_quot[i] > Q_W'(ONE_Q)) ? Q_W'(ONE_Q) : dv_quot[i];
         ax_in[i] = dv_tag.neg[i] ? -OUT_W'(qs) : OUT_W'(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff  <= ax_in;
         dga_ff <= dv_tag.deg;
      end
   end

   // ---- stage B: partial products of X = Y x Z (Z in lanes 0..2, Y in 3..5) ----
   logic signed [XP_W-1:0]  xp_in [6], xp_ff [6];
   logic signed [OUT_W-1:0] axb_ff [6];
   logic                    dgb_ff, vb_ff;

   always_comb begin
      xp_in[0] = ax_ff[4] * ax_ff[2];
      xp_in[1] = ax_ff[5] * ax_ff[1];
      xp_in[2] = ax_ff[5] * ax_ff[0];
      xp_in[3] = ax_ff[3] * ax_ff[2];
      xp_in[4] = ax_ff[3] * ax_ff[1];
      xp_in[5] = ax_ff[4] * ax_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff  <= xp_in;
         axb_ff <= ax_ff;
         dgb_ff <= dga_ff;
      end
   end

   // ---- stage C: round and clamp X to Q1.F, zero a degenerate frame, hold output ----
   logic signed [XP_W-1:0]  xd, xt;
   logic signed [OUT_W-1:0] xo_in [3], xo_ff [3], yo_ff [3], zo_ff [3];
   logic                    dgo_ff;

   always_comb begin
      xd = '0;
      xt = '0;
      for (int i = 0; i < 3; i++) begin
         xd = xp_ff[2*i] - xp_ff[2*i+1];
         xt = (xd + HALF_X) >>> FRAC_BITS;
         if (xt > ONE_X) begin
            xt = ONE_X;
         end else if (xt < -ONE_X) begin
            xt = -ONE_X;
         end
         xo_in[i] = dgb_ff ? '0 : OUT_W'(xt);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xo_ff  <= xo_in;
         dgo_ff <= dgb_ff;
         for (int i = 0; i < 3; i++) begin
            zo_ff[i] <= dgb_ff ? '0 : axb_ff[i];
            yo_ff[i] <= dgb_ff ? '0 : axb_ff[3+i];
         end
      end
   end

   // Valid bits of the back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         va_ff        <= dv_valid;
         vb_ff        <= va_ff;
         out_valid_ff <= vb_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.axis_x_0   = xo_ff[0];
   assign rsp.axis_x_1   = xo_ff[1];
   assign rsp.axis_x_2   = xo_ff[2];
   assign rsp.axis_y_0   = yo_ff[0];
   assign rsp.axis_y_1   = yo_ff[1];
   assign rsp.axis_y_2   = yo_ff[2];
   assign rsp.axis_z_0   = zo_ff[0];
   assign rsp.axis_z_1   = zo_ff[1];
   assign rsp.axis_z_2   = zo_ff[2];
   assign rsp.degenerate = dgo_ff;

endmodule
